// ----- hdl/pixel_graph_edge_weights_defines.svh -----
// Assertion macros used by the checker of the pixel graph edge block.
`ifndef PIXEL_GRAPH_EDGE_WEIGHTS_DEFINES_SVH
`define PIXEL_GRAPH_EDGE_WEIGHTS_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define PGE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pixel graph edge check failed in the same cycle");

// Checks a consequence in the cycle after its antecedent.
`define PGE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pixel graph edge check failed in the following cycle");

`endif

// ----- hdl/pge_pkg.sv -----
// Types and constants of the pixel graph edge block.
`timescale 1ns / 1ps
package pge_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 11;
	localparam int CHAN_W     = 8;
	localparam int NODE_W     = 20;
	localparam int WEIGHT_W   = 13;
	localparam int SUM_W      = 18;
	localparam int RAD_W      = 2 * WEIGHT_W;
	localparam int REM_W      = WEIGHT_W + 3;
	localparam int STEP_W     = 4;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
	localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);
	localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(WEIGHT_W - 1);

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [NODE_W-1:0]   from_node;
		logic [NODE_W-1:0]   to_node;
		logic [WEIGHT_W-1:0] weight;
		logic                last_edge;
	} graph_edge_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] limit);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > limit) begin
			r = limit;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- hdl/pixel_graph_edge_weights.sv -----
// Top level of the pixel graph edge block: edges of the 8-neighbour graph with colour weights.
// Pixels are taken in raster order and yield those of their edges that exist (right, down,
// down-right and up-right), each with its two node indices and the colour distance times 16.
// One pixel is taken at a time: after a transfer the block stalls until all its edges have
// been loaded into the output register. The weight of every edge comes from a sum of
// squares over the three colour channels on one shared squarer, followed by a 13-step square
// root that resolves one result bit a cycle. Writing either register restarts the image at
// pixel 0.
`timescale 1ns / 1ps
module pixel_graph_edge_weights
	import pge_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  pixel_t              pixel,
	output logic                graph_edge_valid,
	input  logic                graph_edge_stall,
	output graph_edge_t         graph_edge
);

	typedef enum logic [2:0] {
		S_IDLE, S_ABOVE, S_RIGHT, S_EDGE, S_SQUARE, S_ROOT, S_EMIT, S_STORE
	} state_t;

	typedef enum logic [1:0] {
		K_RIGHT, K_DOWN, K_DIAG, K_UPRIGHT
	} kind_t;

	state_t             state_q;
	kind_t              kind_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [COL_W-1:0]   col_cnt_q;
	logic [ROW_W-1:0]   row_cnt_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [NODE_W-1:0]  idx_q;
	pixel_t             cur_q;
	pixel_t             left_q;
	pixel_t             upper_left_q;
	pixel_t             above_q;
	pixel_t             right_q;
	pixel_t             rdata_q;
	pixel_t             pa_q;
	pixel_t             pb_q;
	logic [NODE_W-1:0]  from_q;
	logic [NODE_W-1:0]  to_q;
	logic               last_q;
	logic [1:0]         ch_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RAD_W-1:0]   rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [WEIGHT_W-1:0] root_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_valid_q;
	graph_edge_t        out_q;

	pixel_t             row_store [MAX_WIDTH];

	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic               cfg_wr;
	logic               accept;
	logic               emit_load;
	logic [COL_W-1:0]   col_fix;
	logic [ROW_W-1:0]   row_fix;
	logic [COL_W-1:0]   rd_addr;
	logic [NODE_W:0]    prod;
	logic [3:0]         kinds;
	logic [CHAN_W-1:0]  ch_a;
	logic [CHAN_W-1:0]  ch_b;
	logic [CHAN_W-1:0]  diff;
	logic [2*CHAN_W-1:0] sq;
	logic [SUM_W-1:0]   sum_next;
	logic [REM_W-1:0]   rem_sh;
	logic [REM_W-1:0]   trial;
	logic [DIM_W-1:0]   col_inc;
	logic [DIM_W-1:0]   row_inc;

	assign w_eff  = clamp_dim(width_q, WIDTH_LIMIT);
	assign h_eff  = clamp_dim(height_q, HEIGHT_LIMIT);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? APB_DW'(height_q) : APB_DW'(width_q);

	assign pixel_stall      = (state_q != S_IDLE);
	assign accept           = pixel_valid && !pixel_stall;
	assign emit_load        = (state_q == S_EMIT) && (!out_valid_q || !graph_edge_stall);
	assign graph_edge_valid = out_valid_q;
	assign graph_edge       = out_q;

	assign col_fix = (DIM_W'(col_cnt_q) >= w_eff) ? '0 : col_cnt_q;
	assign row_fix = (DIM_W'(row_cnt_q) >= h_eff) ? '0 : row_cnt_q;
	assign rd_addr = (state_q == S_IDLE) ? col_fix : col_q + COL_W'(1);
	assign prod    = (NODE_W+1)'(row_q) * (NODE_W+1)'(w_eff) + (NODE_W+1)'(col_q);

	assign kinds[K_RIGHT]   = (col_q != '0);
	assign kinds[K_DOWN]    = (row_q != '0);
	assign kinds[K_DIAG]    = (row_q != '0) && (col_q != '0);
	assign kinds[K_UPRIGHT] = (row_q != '0) && (DIM_W'(col_q) + DIM_W'(1) < w_eff);

	assign col_inc = DIM_W'(col_q) + DIM_W'(1);
	assign row_inc = DIM_W'(row_q) + DIM_W'(1);

	always_comb begin
		unique case (ch_q)
			2'd0: begin
				ch_a = pa_q.red;
				ch_b = pb_q.red;
			end
			2'd1: begin
				ch_a = pa_q.green;
				ch_b = pb_q.green;
			end
			default: begin
				ch_a = pa_q.blue;
				ch_b = pb_q.blue;
			end
		endcase
		diff     = (ch_a > ch_b) ? ch_a - ch_b : ch_b - ch_a;
		sq       = (2*CHAN_W)'(diff) * (2*CHAN_W)'(diff);
		sum_next = sum_q + SUM_W'(sq);
		rem_sh   = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial    = {1'b0, root_q, 2'b01};
	end

	function automatic kind_t next_kind(input kind_t k);
		kind_t r;
		unique case (k)
			K_RIGHT:   r = K_DOWN;
			K_DOWN:    r = K_DIAG;
			K_DIAG:    r = K_UPRIGHT;
			K_UPRIGHT: r = K_RIGHT;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk) begin
		rdata_q <= row_store[rd_addr];
		if (state_q == S_STORE) begin
			row_store[col_q] <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_IMAGE_WIDTH) begin
				width_q <= pwdata[DIM_W-1:0];
			end else begin
				height_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= K_RIGHT;
			col_cnt_q    <= '0;
			row_cnt_q    <= '0;
			left_q       <= '0;
			upper_left_q <= '0;
			out_valid_q  <= 1'b0;
			ch_q         <= '0;
			step_q       <= '0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !graph_edge_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q   <= pixel;
						col_q   <= col_fix;
						row_q   <= row_fix;
						state_q <= S_ABOVE;
					end
				end
				S_ABOVE: begin
					above_q <= rdata_q;
					idx_q   <= prod[NODE_W-1:0];
					kind_q  <= K_RIGHT;
					state_q <= S_RIGHT;
				end
				S_RIGHT: begin
					right_q <= rdata_q;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					if (kinds[kind_q]) begin
						last_q <= ((kinds >> kind_q) == 4'b0001);
						ch_q   <= '0;
						sum_q  <= '0;
						unique case (kind_q)
							K_RIGHT: begin
								pa_q   <= left_q;
								pb_q   <= cur_q;
								from_q <= idx_q - NODE_W'(1);
								to_q   <= idx_q;
							end
							K_DOWN: begin
								pa_q   <= above_q;
								pb_q   <= cur_q;
								from_q <= idx_q - NODE_W'(w_eff);
								to_q   <= idx_q;
							end
							K_DIAG: begin
								pa_q   <= upper_left_q;
								pb_q   <= cur_q;
								from_q <= idx_q - NODE_W'(w_eff) - NODE_W'(1);
								to_q   <= idx_q;
							end
							K_UPRIGHT: begin
								pa_q   <= cur_q;
								pb_q   <= right_q;
								from_q <= idx_q;
								to_q   <= idx_q - NODE_W'(w_eff) + NODE_W'(1);
							end
						endcase
						state_q <= S_SQUARE;
					end else if (kind_q == K_UPRIGHT) begin
						state_q <= S_STORE;
					end else begin
						kind_q <= next_kind(kind_q);
					end
				end
				S_SQUARE: begin
					sum_q <= sum_next;
					ch_q  <= ch_q + 2'd1;
					if (ch_q == 2'd2) begin
						rad_q   <= {sum_next, 8'b0};
						rem_q   <= '0;
						root_q  <= '0;
						step_q  <= '0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					rad_q <= rad_q << 2;
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[WEIGHT_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[WEIGHT_W-2:0], 1'b0};
					end
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						out_q.from_node <= from_q;
						out_q.to_node   <= to_q;
						out_q.weight    <= root_q;
						out_q.last_edge <= last_q;
						if (kind_q == K_UPRIGHT) begin
							state_q <= S_STORE;
						end else begin
							kind_q  <= next_kind(kind_q);
							state_q <= S_EDGE;
						end
					end
				end
				S_STORE: begin
					left_q       <= cur_q;
					upper_left_q <= above_q;
					if (!cfg_wr) begin
						if (col_inc >= w_eff) begin
							col_cnt_q <= '0;
							row_cnt_q <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
						end else begin
							col_cnt_q <= col_inc[COL_W-1:0];
							row_cnt_q <= row_q;
						end
					end
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_wr) begin
				col_cnt_q <= '0;
				row_cnt_q <= '0;
			end
		end
	end

endmodule

// ----- hdl/pge_checker.sv -----
// Port checker for the pixel graph edge block and its binding to the top level.
`timescale 1ns / 1ps
`include "pixel_graph_edge_weights_defines.svh"
module pge_checker
	import pge_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        pixel_valid,
	input logic        pixel_stall,
	input logic        graph_edge_valid,
	input logic        graph_edge_stall,
	input graph_edge_t graph_edge
);

	`PGE_ASSERT_NEXT(busy_after_transfer, pixel_valid && !pixel_stall, pixel_stall)
	`PGE_ASSERT_NOW(edge_ends_differ, graph_edge_valid, graph_edge.from_node != graph_edge.to_node)
	`PGE_ASSERT_NOW(weight_in_range, graph_edge_valid, graph_edge.weight <= WEIGHT_W'(7067))
	`PGE_ASSERT_NEXT(edge_held, graph_edge_valid && graph_edge_stall, graph_edge_valid && $stable(graph_edge))

endmodule

bind pixel_graph_edge_weights pge_checker u_pge_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the pixel graph edge block, with its own edge predictor.
`timescale 1ns / 1ps
module tb;
	import pge_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned RANDOM_PIXELS = 170;
	localparam logic [23:0] SHOWCASE [11] = '{
		24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'h000000, 24'h808080,
		24'h7F7F7F, 24'h010203, 24'hFEFDFC, 24'h123456, 24'h654321
	};

	class edge_ledger;
		pixel_t           row_mem [MAX_WIDTH];
		pixel_t           left_px;
		pixel_t           upper_left_px;
		int unsigned      col_pos;
		int unsigned      row_pos;
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		graph_edge_t      pending_edges [$];
		int unsigned      errors;

		function new();
			foreach (row_mem[i]) row_mem[i] = '0;
			left_px = '0;
			upper_left_px = '0;
			col_pos = 0;
			row_pos = 0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			errors = 0;
		endfunction

		function void set_dimension(logic reg_sel, logic [DIM_W-1:0] value);
			if (reg_sel == REG_IMAGE_WIDTH) begin
				width_reg = value;
			end else begin
				height_reg = value;
			end
			col_pos = 0;
			row_pos = 0;
		endfunction

		function int unsigned dim_in_use(logic [DIM_W-1:0] value, int unsigned top);
			if (value == '0) return 1;
			if (value > top) return top;
			return value;
		endfunction

		function logic [WEIGHT_W-1:0] colour_distance(pixel_t a, pixel_t b);
			int unsigned dr, dg, db, scaled, root, trial;
			dr = (a.red > b.red) ? int'(a.red) - int'(b.red) : int'(b.red) - int'(a.red);
			dg = (a.green > b.green) ? int'(a.green) - int'(b.green)
				: int'(b.green) - int'(a.green);
			db = (a.blue > b.blue) ? int'(a.blue) - int'(b.blue) : int'(b.blue) - int'(a.blue);
			scaled = (dr * dr + dg * dg + db * db) * 256;
			root = 0;
			for (int bitpos = WEIGHT_W - 1; bitpos >= 0; bitpos--) begin
				trial = root | (1 << bitpos);
				if (trial * trial <= scaled) root = trial;
			end
			return WEIGHT_W'(root);
		endfunction

		function graph_edge_t make_edge(int unsigned head_idx, int unsigned tail_idx,
				pixel_t a, pixel_t b);
			graph_edge_t e;
			e.from_node = NODE_W'(head_idx);
			e.to_node = NODE_W'(tail_idx);
			e.weight = colour_distance(a, b);
			e.last_edge = 1'b0;
			return e;
		endfunction

		function void take_pixel(pixel_t cur);
			int unsigned w, h, col, row, idx, n;
			pixel_t above;
			graph_edge_t found [4];
			w = dim_in_use(width_reg, MAX_WIDTH);
			h = dim_in_use(height_reg, MAX_HEIGHT);
			col = (col_pos >= w) ? 0 : col_pos;
			row = (row_pos >= h) ? 0 : row_pos;
			idx = row * w + col;
			above = row_mem[col];
			n = 0;
			if (col > 0) begin
				found[n] = make_edge(idx - 1, idx, left_px, cur);
				n++;
			end
			if (row > 0) begin
				found[n] = make_edge(idx - w, idx, above, cur);
				n++;
			end
			if (row > 0 && col > 0) begin
				found[n] = make_edge(idx - w - 1, idx, upper_left_px, cur);
				n++;
			end
			if (row > 0 && col + 1 < w) begin
				found[n] = make_edge(idx, idx - w + 1, cur, row_mem[col + 1]);
				n++;
			end
			if (n > 0) found[n - 1].last_edge = 1'b1;
			for (int i = 0; i < n; i++) pending_edges = {pending_edges, found[i]};
			upper_left_px = above;
			row_mem[col] = cur;
			left_px = cur;
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) row = 0;
			end
			col_pos = col;
			row_pos = row;
		endfunction

		function void match_edge(graph_edge_t seen);
			graph_edge_t want;
			if (pending_edges.size() == 0) begin
				errors++;
				$display("%0t: edge transfer with none expected, expected nothing, got %p",
					$time, seen);
				return;
			end
			want = pending_edges.pop_front();
			if (seen.from_node !== want.from_node) begin
				errors++;
				$display("%0t: from_node expected %0d, got %0d", $time, want.from_node,
					seen.from_node);
			end
			if (seen.to_node !== want.to_node) begin
				errors++;
				$display("%0t: to_node expected %0d, got %0d", $time, want.to_node,
					seen.to_node);
			end
			if (seen.weight !== want.weight) begin
				errors++;
				$display("%0t: weight expected %0d, got %0d", $time, want.weight, seen.weight);
			end
			if (seen.last_edge !== want.last_edge) begin
				errors++;
				$display("%0t: last_edge expected %0b, got %0b", $time, want.last_edge,
					seen.last_edge);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              pixel_valid;
	logic              pixel_stall;
	pixel_t            pixel;
	logic              graph_edge_valid;
	logic              graph_edge_stall;
	graph_edge_t       graph_edge;

	edge_ledger  ledger;
	int unsigned send_gap_pct;
	int unsigned stall_pct;
	int unsigned cycle_count;

	pixel_graph_edge_weights dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.pixel_valid      (pixel_valid),
		.pixel_stall      (pixel_stall),
		.pixel            (pixel),
		.graph_edge_valid (graph_edge_valid),
		.graph_edge_stall (graph_edge_stall),
		.graph_edge       (graph_edge)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		graph_edge_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(negedge clk) begin
		if (arst_n && graph_edge_valid && !graph_edge_stall) ledger.match_edge(graph_edge);
	end

	task automatic send_pixel(input pixel_t px);
		logic taken;
		if ($urandom_range(99) < send_gap_pct) begin
			pixel_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		forever begin
			@(negedge clk);
			taken = !pixel_stall;
			@(posedge clk);
			if (taken) break;
		end
		ledger.take_pixel(px);
	endtask

	task automatic end_phase();
		pixel_valid <= 1'b0;
		do @(posedge clk); while (ledger.pending_edges.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [DIM_W-1:0] value);
		logic ready_seen;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({reg_sel, 2'b00});
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(negedge clk);
			ready_seen = pready;
			@(posedge clk);
			if (ready_seen) break;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ledger.set_dimension(reg_sel, value);
		@(posedge clk);
	endtask

	task automatic new_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		end_phase();
		apb_write(REG_IMAGE_WIDTH, w);
		apb_write(REG_IMAGE_HEIGHT, h);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t p;
		case ($urandom_range(3))
			0: begin
				p.red = $urandom_range(1) ? 8'hFF : 8'h00;
				p.green = $urandom_range(1) ? 8'hFF : 8'h00;
				p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			1: begin
				p = pixel_t'(24'($urandom) & 24'h030303);
			end
			default: begin
				p = pixel_t'(24'($urandom));
			end
		endcase
		return p;
	endfunction

	function automatic logic [DIM_W-1:0] random_dim(input int unsigned usual_top);
		logic [DIM_W-1:0] d;
		case ($urandom_range(9))
			0: d = '0;
			1: d = DIM_W'($urandom_range(MAX_WIDTH + 1, 2 ** DIM_W - 1));
			2: d = DIM_W'(1);
			default: d = DIM_W'($urandom_range(2, usual_top));
		endcase
		return d;
	endfunction

	initial begin
		int unsigned sent;
		int unsigned phase;
		int unsigned count;
		ledger = new();
		cycle_count = 0;
		send_gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel_valid = 1'b0;
		pixel = '0;
		graph_edge_stall = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default geometry straight out of reset, then a 3x3 image that wraps.
		send_pixel(pixel_t'(24'h000000));
		send_pixel(pixel_t'(24'hFFFFFF));
		send_pixel(pixel_t'(24'hFFFFFF));
		new_image(DIM_W'(3), DIM_W'(3));
		foreach (SHOWCASE[i]) send_pixel(pixel_t'(SHOWCASE[i]));
		// A zero width counts as one column; a zero height as one row.
		new_image(DIM_W'(0), DIM_W'(2));
		send_pixel(pixel_t'(24'h00FF00));
		send_pixel(pixel_t'(24'hFF00FF));
		send_pixel(pixel_t'(24'h000000));
		new_image(DIM_W'(1), DIM_W'(0));
		send_pixel(pixel_t'(24'hFFFFFF));
		send_pixel(pixel_t'(24'h000000));
		// A register write part way through an image restarts it at pixel 0.
		new_image(DIM_W'(2), DIM_W'(3));
		repeat (3) send_pixel(random_pixel());
		end_phase();
		apb_write(REG_IMAGE_HEIGHT, DIM_W'(3));
		repeat (3) send_pixel(random_pixel());

		sent = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			new_image(random_dim(8), random_dim(6));
			case (phase % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_gap_pct = 49;
					stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct = 49;
				end
				default: begin
					send_gap_pct = 16;
					stall_pct = 16;
				end
			endcase
			count = $urandom_range(8, 30);
			repeat (count) send_pixel(random_pixel());
			sent += count;
			phase++;
		end

		// A width above the largest counts as the largest.
		new_image('1, DIM_W'(2));
		send_gap_pct = 0;
		stall_pct = 0;
		repeat (6) send_pixel(random_pixel());
		end_phase();

		if (ledger.errors == 0 && ledger.pending_edges.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/pge_pkg.sv
hdl/pixel_graph_edge_weights.sv
hdl/pge_checker.sv
tb/sv/tb.sv
